// ===== hdl/ipid_pkg.sv =====
package ipid_pkg;

  localparam int CHANNELS_DEF = 2;

  localparam int GAIN_W  = 16;
  localparam int SPEED_W = 16;
  localparam int ERR_W   = 17;
  localparam int ACC_W   = 25;
  localparam int DRIVE_W = 17;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  localparam int D1_W   = ERR_W + 1;
  localparam int D2_W   = ERR_W + 2;
  localparam int PP_W   = GAIN_W + 1 + D1_W;
  localparam int PI_W   = GAIN_W + 1 + ERR_W;
  localparam int PD_W   = GAIN_W + 1 + D2_W;
  localparam int SUM_W  = PD_W + 1;
  localparam int FRAC_W = 8;
  localparam int STEP_W = SUM_W - FRAC_W;
  localparam int ACCS_W = STEP_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP_LEFT     = 3'd0,
    REG_KI_LEFT     = 3'd1,
    REG_KD_LEFT     = 3'd2,
    REG_KP_RIGHT    = 3'd3,
    REG_KI_RIGHT    = 3'd4,
    REG_KD_RIGHT    = 3'd5,
    REG_DRIVE_LIMIT = 3'd6,
    REG_DEADBAND    = 3'd7
  } cfg_reg_t;

  localparam logic OP_COMPUTE = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  localparam logic WHEEL_LEFT = 1'b0;

  localparam logic [CFG_W-1:0] DRIVE_LIMIT_RST = 16'd1000;
  localparam logic [CFG_W-1:0] DEADBAND_RST    = 16'd256;

endpackage

// ===== hdl/incremental_pid_two_wheel_core.sv =====
// Incremental PID speed controller for a set of wheels, one history per wheel.
// Input channel (in_valid / in_stall) carries one word per request: an opcode
// (compute step or clear history), a wheel number and target and measured
// speeds in signed Q8.8. Every accepted word yields exactly one result word on
// the output channel (out_valid / out_stall): the clamped integer drive and a
// flag that is set when the zero-target deadband forced the drive to zero.
// An accepted word is held in the input register; the three gain products, the
// accumulate and the clamp are then formed in a single pass into the output
// register. A new word is accepted every cycle while the output is not stalled;
// the wheel's history is written at the same edge as the result, so a following
// word for the same wheel sees it at once.
// When the receiver stalls, the result holds in the output register, the next
// word waits in the input register, and in_stall rises only once both are full.
// Gains, drive limit and deadband are written through the cfg port; the user
// must write them only while the block is idle; the block does not enforce it.
// Synchronous active-low reset empties both registers, clears every wheel's
// history and loads the register defaults (gains 0, limit 1000, deadband 256).
module incremental_pid_two_wheel_core #(
  parameter int CHANNELS = ipid_pkg::CHANNELS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [ipid_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ipid_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_opcode,
  input  logic                                   in_wheel,
  input  logic signed [ipid_pkg::SPEED_W-1:0]    in_target_speed,
  input  logic signed [ipid_pkg::SPEED_W-1:0]    in_measured_speed,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [ipid_pkg::DRIVE_W-1:0]    out_drive,
  output logic                                   out_deadband_hit
);

  localparam int GW = ipid_pkg::GAIN_W;
  localparam int EW = ipid_pkg::ERR_W;
  localparam int AW = ipid_pkg::ACC_W;

  logic [GW-1:0] kp_l_r, ki_l_r, kd_l_r, kp_r_r, ki_r_r, kd_r_r;
  logic [GW-1:0] limit_r, deadband_r;

  logic                                 in_valid_r;
  logic                                 opcode_r;
  logic                                 wheel_r;
  logic signed [ipid_pkg::SPEED_W-1:0]  target_r;
  logic signed [ipid_pkg::SPEED_W-1:0]  measured_r;

  logic signed [AW-1:0] acc_r [CHANNELS];
  logic signed [EW-1:0] e1_r  [CHANNELS];
  logic signed [EW-1:0] e2_r  [CHANNELS];

  logic                                 out_valid_r;
  logic signed [ipid_pkg::DRIVE_W-1:0]  drive_r;
  logic                                 deadband_hit_r;

  logic advance;
  logic wheel_ok;
  logic signed [AW-1:0] acc_sel;
  logic signed [EW-1:0] e1_sel, e2_sel;
  logic [GW-1:0] kp, ki, kd;
  logic signed [EW-1:0] err;
  logic signed [EW:0] err_x, db_x;
  logic in_deadband;
  logic signed [ipid_pkg::D1_W-1:0] d1;
  logic signed [ipid_pkg::D2_W-1:0] d2;
  logic signed [ipid_pkg::PP_W-1:0] prod_p;
  logic signed [ipid_pkg::PI_W-1:0] prod_i;
  logic signed [ipid_pkg::PD_W-1:0] prod_d;
  logic signed [ipid_pkg::SUM_W-1:0] sum;
  logic signed [ipid_pkg::STEP_W-1:0] step;
  logic signed [ipid_pkg::ACCS_W-1:0] acc_sum, lim_x;
  logic signed [AW-1:0] acc_nxt;
  logic [AW-1:0] acc_mag;
  logic [ipid_pkg::DRIVE_W-1:0] drv_mag;
  logic signed [ipid_pkg::DRIVE_W-1:0] drive_nxt;
  logic deadband_hit_nxt;
  logic hist_clear, hist_step;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;
  assign out_valid        = out_valid_r;
  assign out_drive        = drive_r;
  assign out_deadband_hit = deadband_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_l_r     <= '0;
      ki_l_r     <= '0;
      kd_l_r     <= '0;
      kp_r_r     <= '0;
      ki_r_r     <= '0;
      kd_r_r     <= '0;
      limit_r    <= ipid_pkg::DRIVE_LIMIT_RST;
      deadband_r <= ipid_pkg::DEADBAND_RST;
    end else if (cfg_wr_en) begin
      unique case (ipid_pkg::cfg_reg_t'(cfg_index))
        ipid_pkg::REG_KP_LEFT:     kp_l_r     <= cfg_data;
        ipid_pkg::REG_KI_LEFT:     ki_l_r     <= cfg_data;
        ipid_pkg::REG_KD_LEFT:     kd_l_r     <= cfg_data;
        ipid_pkg::REG_KP_RIGHT:    kp_r_r     <= cfg_data;
        ipid_pkg::REG_KI_RIGHT:    ki_r_r     <= cfg_data;
        ipid_pkg::REG_KD_RIGHT:    kd_r_r     <= cfg_data;
        ipid_pkg::REG_DRIVE_LIMIT: limit_r    <= cfg_data;
        ipid_pkg::REG_DEADBAND:    deadband_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      opcode_r   <= in_opcode;
      wheel_r    <= in_wheel;
      target_r   <= in_target_speed;
      measured_r <= in_measured_speed;
    end
  end

  always_comb begin
    wheel_ok = 32'(wheel_r) < CHANNELS;
    acc_sel  = '0;
    e1_sel   = '0;
    e2_sel   = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      if (32'(wheel_r) == ch) begin
        acc_sel = acc_r[ch];
        e1_sel  = e1_r[ch];
        e2_sel  = e2_r[ch];
      end
    end
  end

  always_comb begin
    if (wheel_r == ipid_pkg::WHEEL_LEFT) begin
      kp = kp_l_r;
      ki = ki_l_r;
      kd = kd_l_r;
    end else begin
      kp = kp_r_r;
      ki = ki_r_r;
      kd = kd_r_r;
    end
  end

  always_comb begin
    err   = EW'(target_r) - EW'(measured_r);
    err_x = (EW+1)'(err);
    db_x  = $signed({2'b00, deadband_r});
    in_deadband = (target_r == '0) && (err_x > -db_x) && (err_x < db_x);

    d1 = ipid_pkg::D1_W'(err) - ipid_pkg::D1_W'(e1_sel);
    d2 = ipid_pkg::D2_W'(err) - ipid_pkg::D2_W'(e1_sel) - ipid_pkg::D2_W'(e1_sel)
         + ipid_pkg::D2_W'(e2_sel);

    prod_p = $signed({1'b0, kp}) * d1;
    prod_i = $signed({1'b0, ki}) * err;
    prod_d = $signed({1'b0, kd}) * d2;

    sum  = ipid_pkg::SUM_W'(prod_p) + ipid_pkg::SUM_W'(prod_i) + ipid_pkg::SUM_W'(prod_d);
    step = ipid_pkg::STEP_W'(sum >>> ipid_pkg::FRAC_W);

    acc_sum = ipid_pkg::ACCS_W'(acc_sel) + ipid_pkg::ACCS_W'(step);
    lim_x   = $signed({{(ipid_pkg::ACCS_W-GW-ipid_pkg::FRAC_W){1'b0}}, limit_r,
                       {ipid_pkg::FRAC_W{1'b0}}});
    if (acc_sum > lim_x) begin
      acc_nxt = AW'(lim_x);
    end else if (acc_sum < -lim_x) begin
      acc_nxt = AW'(-lim_x);
    end else begin
      acc_nxt = AW'(acc_sum);
    end

    acc_mag = acc_nxt[AW-1] ? AW'(-acc_nxt) : AW'(acc_nxt);
    drv_mag = acc_mag[AW-1:ipid_pkg::FRAC_W];
    drive_nxt = acc_nxt[AW-1] ? -$signed(drv_mag) : $signed(drv_mag);

    hist_clear       = 1'b0;
    hist_step        = 1'b0;
    deadband_hit_nxt = 1'b0;
    if (!wheel_ok) begin
      drive_nxt = '0;
    end else if (opcode_r == ipid_pkg::OP_CLEAR) begin
      hist_clear = 1'b1;
      drive_nxt  = '0;
    end else if (in_deadband) begin
      hist_clear       = 1'b1;
      deadband_hit_nxt = 1'b1;
      drive_nxt        = '0;
    end else begin
      hist_step = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        acc_r[ch] <= '0;
        e1_r[ch]  <= '0;
        e2_r[ch]  <= '0;
      end
    end else if (advance && in_valid_r) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        if (32'(wheel_r) == ch) begin
          if (hist_clear) begin
            acc_r[ch] <= '0;
            e1_r[ch]  <= '0;
            e2_r[ch]  <= '0;
          end else if (hist_step) begin
            acc_r[ch] <= acc_nxt;
            e1_r[ch]  <= err;
            e2_r[ch]  <= e1_sel;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      drive_r        <= drive_nxt;
      deadband_hit_r <= deadband_hit_nxt;
    end
  end

endmodule

// ===== hdl/ipid_checker.sv =====
module ipid_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [ipid_pkg::DRIVE_W-1:0] out_drive,
  input logic                                out_deadband_hit
);

  // The output register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_drive) && $stable(out_deadband_hit))
    else $error("stalled result word changed");

  // A deadband result always carries zero drive.
  a_deadband_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_deadband_hit |-> out_drive == '0)
    else $error("deadband result with nonzero drive");

  // An accepted word reaches the output when the receiver is free.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("accepted word did not reach the output");

  // The input side only stalls while a result word is waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result word");

endmodule

bind incremental_pid_two_wheel_core ipid_checker u_ipid_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_drive        (out_drive),
  .out_deadband_hit (out_deadband_hit)
);
